[hw/rtl/i2cmw_pkg.sv]
// Shared types and constants for the I2C write master.
// Used by i2cmw_timer, i2cmw_ctrl and i2c_master_write_core.
`default_nettype none

package i2cmw_pkg;

  localparam int unsigned ADDR_W      = 7;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned BIT_IDX_W   = 4;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned DEF_TICK_WIDTH  = 16;
  localparam int unsigned DEF_COUNT_WIDTH = 8;

  localparam logic [LEN_W-1:0] RESET_HALF_BIT   = 16'd250;
  localparam logic [LEN_W-1:0] RESET_START_HOLD = 16'd3750;
  localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ADDR_NACK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DATA_NACK = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_ADDR = 2'd0,
    CFG_HALF_BIT    = 2'd1,
    CFG_START_HOLD  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_WAIT_BUS   = 4'd1,
    PH_START_SDA  = 4'd2,
    PH_START_HOLD = 4'd3,
    PH_BIT_LOW    = 4'd4,
    PH_BIT_HIGH   = 4'd5,
    PH_ACK_LOW    = 4'd6,
    PH_ACK_HIGH   = 4'd7,
    PH_LOAD       = 4'd8,
    PH_STOP_LOW   = 4'd9,
    PH_STOP_SCL   = 4'd10,
    PH_STOP_SDA   = 4'd11,
    PH_DONE       = 4'd12
  } phase_t;

  typedef struct packed {
    logic              sda_level;
    logic              scl_level;
    logic              go;
    logic [BYTE_W-1:0] byte_count;
    logic              byte_valid;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic                scl_pull_low;
    logic                sda_pull_low;
    logic                want_byte;
    logic                busy_res;
    logic                done_res;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // phase timer request from the controller
  typedef struct packed {
    logic             run;
    logic [LEN_W-1:0] len;
  } timer_req_t;

endpackage

`default_nettype wire

[hw/rtl/i2cmw_timer.sv]
// Phase tick counter: counts ticks of a timed phase and flags its last tick.
// Depends on i2cmw_pkg.
`default_nettype none

module i2cmw_timer #(
  parameter int unsigned TICK_WIDTH = i2cmw_pkg::DEF_TICK_WIDTH
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     step,
  input  i2cmw_pkg::timer_req_t   req,
  output logic                    elapsed
);
  import i2cmw_pkg::*;

  localparam int unsigned LW = ((TICK_WIDTH > LEN_W) ? TICK_WIDTH : LEN_W) + 1;

  logic [TICK_WIDTH-1:0] tick_r, tick_nxt;
  logic [LW-1:0]         lim;
  logic [LW-1:0]         cap;
  logic [LW-1:0]         tick_p1;

  // zero length counts as one tick, lengths past the counter range clip
  always_comb begin
    cap = LW'(1) << TICK_WIDTH;
    lim = LW'(req.len);
    if (lim == '0) lim = LW'(1);
    if (lim > cap) lim = cap;
    tick_p1  = LW'(tick_r) + LW'(1);
    elapsed  = (tick_p1 >= lim);
    tick_nxt = tick_r;
    if (step && req.run) begin
      tick_nxt = elapsed ? '0 : tick_p1[TICK_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else begin
      tick_r <= tick_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/i2cmw_ctrl.sv]
// Transfer sequencer: phase state machine, bit shifter, byte count and status.
// Depends on i2cmw_pkg; paired with i2cmw_timer for phase lengths.
`default_nettype none

module i2cmw_ctrl #(
  parameter int unsigned COUNT_WIDTH = i2cmw_pkg::DEF_COUNT_WIDTH
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               step,
  input  i2cmw_pkg::in_item_t               item,
  input  wire [i2cmw_pkg::ADDR_W-1:0]       target_address,
  input  wire [i2cmw_pkg::LEN_W-1:0]        half_bit_ticks,
  input  wire [i2cmw_pkg::LEN_W-1:0]        start_hold_ticks,
  input  wire                               elapsed,
  output i2cmw_pkg::timer_req_t             treq,
  output i2cmw_pkg::out_item_t              res
);
  import i2cmw_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [BIT_IDX_W-1:0]   bit_idx_r, bit_idx_nxt, bit_idx_inc;
  logic [BYTE_W-1:0]      shift_r, shift_nxt;
  logic [COUNT_WIDTH-1:0] bytes_left_r, bytes_left_nxt;
  logic [STATUS_W-1:0]    code_r, code_nxt;
  logic                   data_phase_r, data_phase_nxt;
  logic                   bit_low;

  assign bit_low     = ~shift_r[BYTE_W-1];
  assign bit_idx_inc = bit_idx_r + BIT_IDX_W'(1);

  // line outputs are a function of the phase and, in the bit phases, of the shifter MSB
  always_comb begin
    res        = '0;
    res.status = code_r;
    res.busy_res = 1'b1;
    treq.run = 1'b0;
    treq.len = (phase_r == PH_START_HOLD) ? start_hold_ticks : half_bit_ticks;
    unique case (phase_r)
      PH_IDLE:       res.busy_res = 1'b0;
      PH_WAIT_BUS:   ;
      PH_START_SDA:  begin
        res.sda_pull_low = 1'b1;
        treq.run = 1'b1;
      end
      PH_START_HOLD: begin
        res.sda_pull_low = 1'b1;
        res.scl_pull_low = 1'b1;
        treq.run = 1'b1;
      end
      PH_BIT_LOW:    begin
        res.scl_pull_low = 1'b1;
        res.sda_pull_low = bit_low;
        treq.run = 1'b1;
      end
      PH_BIT_HIGH:   begin
        res.sda_pull_low = bit_low;
        treq.run = 1'b1;
      end
      PH_ACK_LOW:    begin
        res.scl_pull_low = 1'b1;
        treq.run = 1'b1;
      end
      PH_ACK_HIGH:   treq.run = 1'b1;
      PH_LOAD:       begin
        res.scl_pull_low = 1'b1;
        res.want_byte = 1'b1;
      end
      PH_STOP_LOW:   begin
        res.scl_pull_low = 1'b1;
        res.sda_pull_low = 1'b1;
        treq.run = 1'b1;
      end
      PH_STOP_SCL:   begin
        res.sda_pull_low = 1'b1;
        treq.run = 1'b1;
      end
      PH_STOP_SDA:   treq.run = 1'b1;
      default: begin
        res.busy_res = 1'b0;
        res.done_res = 1'b1;
      end
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    bit_idx_nxt    = bit_idx_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    code_nxt       = code_r;
    data_phase_nxt = data_phase_r;
    if (step) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (item.go) begin
            bytes_left_nxt = COUNT_WIDTH'(item.byte_count);
            code_nxt       = ST_OK;
            data_phase_nxt = 1'b0;
            phase_nxt      = PH_WAIT_BUS;
          end
        end
        PH_WAIT_BUS: begin
          if (item.sda_level && item.scl_level) phase_nxt = PH_START_SDA;
        end
        PH_START_SDA: begin
          if (elapsed) phase_nxt = PH_START_HOLD;
        end
        PH_START_HOLD: begin
          if (elapsed) begin
            data_phase_nxt = 1'b0;
            shift_nxt      = {target_address, 1'b0};  // R/W = write
            bit_idx_nxt    = '0;
            phase_nxt      = PH_BIT_LOW;
          end
        end
        PH_BIT_LOW: begin
          if (elapsed) phase_nxt = PH_BIT_HIGH;
        end
        PH_BIT_HIGH: begin
          if (elapsed) begin
            shift_nxt   = {shift_r[BYTE_W-2:0], 1'b0};
            bit_idx_nxt = bit_idx_inc;
            phase_nxt   = (bit_idx_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_BIT_LOW;
          end
        end
        PH_ACK_LOW: begin
          if (elapsed) phase_nxt = PH_ACK_HIGH;
        end
        PH_ACK_HIGH: begin
          if (elapsed) begin
            priority if (item.sda_level) begin
              code_nxt  = data_phase_r ? ST_DATA_NACK : ST_ADDR_NACK;
              phase_nxt = PH_STOP_LOW;
            end else if (bytes_left_r == '0) begin
              phase_nxt = PH_STOP_LOW;
            end else begin
              phase_nxt = PH_LOAD;
            end
          end
        end
        PH_LOAD: begin
          if (item.byte_valid) begin
            bytes_left_nxt = bytes_left_r - COUNT_WIDTH'(1);
            data_phase_nxt = 1'b1;
            shift_nxt      = item.data_byte;
            bit_idx_nxt    = '0;
            phase_nxt      = PH_BIT_LOW;
          end
        end
        PH_STOP_LOW: begin
          if (elapsed) phase_nxt = PH_STOP_SCL;
        end
        PH_STOP_SCL: begin
          if (elapsed) phase_nxt = PH_STOP_SDA;
        end
        PH_STOP_SDA: begin
          if (elapsed) phase_nxt = PH_DONE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_idx_r    <= '0;
      shift_r      <= '0;
      bytes_left_r <= '0;
      code_r       <= ST_OK;
      data_phase_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      bit_idx_r    <= bit_idx_nxt;
      shift_r      <= shift_nxt;
      bytes_left_r <= bytes_left_nxt;
      code_r       <= code_nxt;
      data_phase_r <= data_phase_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/i2c_master_write_core.sv]
// I2C write master, one request per clock tick carrying the sampled SDA/SCL
// levels and the go / byte handshake; each request yields one result with
// the open-drain pull controls, byte request, busy, done pulse and status.
// A request enters an input register, the sequencer and phase timer act
// on it combinationally, and the result lands in an output register: one
// request per cycle sustained while the output register is free or being
// read. While a result waits in the output register, one more request
// can enter the input register; the input then stalls until the result
// is taken. SCL timing is set purely by the tick counts in the
// configuration registers (no clock stretching).
// Write configuration only while no transfer is in progress.
// Depends on i2cmw_pkg, i2cmw_timer and i2cmw_ctrl.
`default_nettype none

module i2c_master_write_core #(
  parameter int unsigned TICK_WIDTH  = i2cmw_pkg::DEF_TICK_WIDTH,
  parameter int unsigned COUNT_WIDTH = i2cmw_pkg::DEF_COUNT_WIDTH
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  i2cmw_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output i2cmw_pkg::out_item_t               out_data,
  input  wire                                cfg_we,
  input  wire [i2cmw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [i2cmw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import i2cmw_pkg::*;

  logic              s1_valid_r;
  in_item_t          s1_item_r;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              step;

  logic [ADDR_W-1:0] target_addr_r;
  logic [LEN_W-1:0]  half_bit_r;
  logic [LEN_W-1:0]  start_hold_r;

  timer_req_t        treq;
  logic              elapsed;
  out_item_t         res;

  assign step      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || step;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_addr_r <= '0;
      half_bit_r    <= RESET_HALF_BIT;
      start_hold_r  <= RESET_START_HOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_ADDR: target_addr_r <= cfg_wdata[ADDR_W-1:0];
        CFG_HALF_BIT:    half_bit_r    <= cfg_wdata[LEN_W-1:0];
        CFG_START_HOLD:  start_hold_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  i2cmw_timer #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_timer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .req     (treq),
    .elapsed (elapsed)
  );

  i2cmw_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .item             (s1_item_r),
    .target_address   (target_addr_r),
    .half_bit_ticks   (half_bit_r),
    .start_hold_ticks (start_hold_r),
    .elapsed          (elapsed),
    .treq             (treq),
    .res              (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

`ifndef SYNTH
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("done pulse while busy");

  a_want_holds_scl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.want_byte |-> out_data_r.scl_pull_low)
    else $error("byte request with SCL released");

  a_idle_releases: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.busy_res |->
      !out_data_r.scl_pull_low && !out_data_r.sda_pull_low)
    else $error("bus driven while not busy");

  a_no_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_ready) |-> in_ready)
    else $error("input stalled with free result register");

  a_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("processed request did not produce a result");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for i2c_master_write_core: streams sampled bus ticks, predicts
// every pin/status result in a scoreboard class and compares them in order.
// Depends on i2cmw_pkg and the core RTL only.

module tb;
  import i2cmw_pkg::*;

  localparam int IN_W        = $bits(in_item_t);
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 64;
  localparam int TAIL_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1000;
  localparam int MAX_PRINTS  = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  class i2c_write_board;
    logic [ADDR_W-1:0]    addr;
    logic [LEN_W-1:0]     half_len;
    logic [LEN_W-1:0]     hold_len;
    phase_t               phase;
    logic [LEN_W-1:0]     ticks;
    logic [BIT_IDX_W-1:0] bit_idx;
    logic [BYTE_W-1:0]    shifter;
    logic [BYTE_W-1:0]    left;
    logic [STATUS_W-1:0]  code;
    bit                   in_data_frame;
    out_item_t            due_pins[$];
    int                   errors;
    int                   taken;
    int                   seen;

    function new();
      addr = '0;
      half_len = RESET_HALF_BIT;
      hold_len = RESET_START_HOLD;
      phase = PH_IDLE;
      ticks = '0;
      bit_idx = '0;
      shifter = '0;
      left = '0;
      code = ST_OK;
      in_data_frame = 1'b0;
      errors = 0;
      taken = 0;
      seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_TARGET_ADDR: addr = v[ADDR_W-1:0];
        CFG_HALF_BIT:    half_len = v;
        CFG_START_HOLD:  hold_len = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return due_pins.size();
    endfunction

    // a zero length counts as one tick
    function bit last_tick(logic [LEN_W-1:0] len);
      int span;
      span = (len == '0) ? 1 : int'(len);
      return int'(ticks) + 1 >= span;
    endfunction

    function bit advance(logic [LEN_W-1:0] len);
      if (last_tick(len)) begin
        ticks = '0;
        return 1'b1;
      end
      ticks++;
      return 1'b0;
    endfunction

    function void go_to(phase_t nxt);
      phase = nxt;
      ticks = '0;
    endfunction

    function void begin_frame(logic [BYTE_W-1:0] v);
      shifter = v;
      bit_idx = '0;
      go_to(PH_BIT_LOW);
    endfunction

    // outputs follow the phase held before this request
    function void take_request(in_item_t it);
      out_item_t e;
      e = '0;
      e.busy_res = 1'b1;
      e.status = code;
      case (phase)
        PH_IDLE:       e.busy_res = 1'b0;
        PH_WAIT_BUS:   ;
        PH_START_SDA:  e.sda_pull_low = 1'b1;
        PH_START_HOLD: begin
          e.sda_pull_low = 1'b1;
          e.scl_pull_low = 1'b1;
        end
        PH_BIT_LOW: begin
          e.scl_pull_low = 1'b1;
          e.sda_pull_low = ~shifter[BYTE_W-1];
        end
        PH_BIT_HIGH:   e.sda_pull_low = ~shifter[BYTE_W-1];
        PH_ACK_LOW:    e.scl_pull_low = 1'b1;
        PH_ACK_HIGH:   ;
        PH_LOAD: begin
          e.scl_pull_low = 1'b1;
          e.want_byte = 1'b1;
        end
        PH_STOP_LOW: begin
          e.scl_pull_low = 1'b1;
          e.sda_pull_low = 1'b1;
        end
        PH_STOP_SCL:   e.sda_pull_low = 1'b1;
        PH_STOP_SDA:   ;
        default: begin
          e.busy_res = 1'b0;
          e.done_res = 1'b1;
        end
      endcase
      due_pins.push_back(e);
      taken++;

      case (phase)
        PH_IDLE: begin
          if (it.go) begin
            left = it.byte_count;
            code = ST_OK;
            in_data_frame = 1'b0;
            go_to(PH_WAIT_BUS);
          end
        end
        PH_WAIT_BUS:   if (it.sda_level && it.scl_level) go_to(PH_START_SDA);
        PH_START_SDA:  if (advance(half_len)) go_to(PH_START_HOLD);
        PH_START_HOLD: begin
          if (advance(hold_len)) begin
            in_data_frame = 1'b0;
            begin_frame({addr, 1'b0});
          end
        end
        PH_BIT_LOW:    if (advance(half_len)) go_to(PH_BIT_HIGH);
        PH_BIT_HIGH: begin
          if (advance(half_len)) begin
            shifter = {shifter[BYTE_W-2:0], 1'b0};
            bit_idx++;
            go_to(bit_idx >= BITS_PER_BYTE ? PH_ACK_LOW : PH_BIT_LOW);
          end
        end
        PH_ACK_LOW:    if (advance(half_len)) go_to(PH_ACK_HIGH);
        PH_ACK_HIGH: begin
          if (advance(half_len)) begin
            if (it.sda_level) begin
              code = in_data_frame ? ST_DATA_NACK : ST_ADDR_NACK;
              go_to(PH_STOP_LOW);
            end else if (left == '0) begin
              go_to(PH_STOP_LOW);
            end else begin
              go_to(PH_LOAD);
            end
          end
        end
        PH_LOAD: begin
          if (it.byte_valid) begin
            left--;
            in_data_frame = 1'b1;
            begin_frame(it.data_byte);
          end
        end
        PH_STOP_LOW:   if (advance(half_len)) go_to(PH_STOP_SCL);
        PH_STOP_SCL:   if (advance(half_len)) go_to(PH_STOP_SDA);
        PH_STOP_SDA:   if (advance(half_len)) go_to(PH_DONE);
        default:       go_to(PH_IDLE);
      endcase
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare(string field, logic [1:0] got, logic [1:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0d want %0d", seen, field, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t e;
      if (due_pins.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending (%h)", seen, got));
        seen++;
        return;
      end
      e = due_pins.pop_front();
      compare("scl_pull_low", got.scl_pull_low, e.scl_pull_low);
      compare("sda_pull_low", got.sda_pull_low, e.sda_pull_low);
      compare("want_byte", got.want_byte, e.want_byte);
      compare("busy_res", got.busy_res, e.busy_res);
      compare("done_res", got.done_res, e.done_res);
      compare("status", got.status, e.status);
      seen++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  i2c_write_board sb = new();

  i2c_master_write_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic in_item_t noise_tick();
    in_item_t it;
    it = IN_W'($urandom);
    return it;
  endfunction

  // offer one request and hold it until the core takes it
  task automatic push_tick(input in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.take_request(it);
  endtask

  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic sender_pause();
    if (quiet) return;
    if ($urandom_range(0, 399) == 0) drain();
    else if ($urandom_range(0, 9) == 0) idle_gap(int'($urandom_range(1, 8)));
  endtask

  task automatic idle_ticks(input int n);
    in_item_t it;
    repeat (n) begin
      it = noise_tick();
      it.go = 1'b0;
      push_tick(it);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // only with the bus idle and every result in
  task automatic reconfigure(input logic [ADDR_W-1:0] a, input logic [LEN_W-1:0] half,
                             input logic [LEN_W-1:0] hold);
    drain();
    repeat (2) @(posedge clk);
    write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    write_reg(CFG_TARGET_ADDR, CFG_DATA_W'(a));
    write_reg(CFG_HALF_BIT, half);
    write_reg(CFG_START_HOLD, hold);
    cfg_we <= 1'b0;
  endtask

  // One write transfer. nack_at: -1 none, 0 address, k data byte k.
  // Quiet transfers keep the lines high, send fill / ~fill and raise go in the done tick.
  task automatic run_xfer(input logic [BYTE_W-1:0] count, input int nack_at,
                          input int busy_ticks, input bit noisy,
                          input logic [BYTE_W-1:0] fill);
    in_item_t it;
    int waited;
    int frame;
    waited = 0;
    it = noise_tick();
    it.go = 1'b1;
    it.byte_count = count;
    push_tick(it);
    sender_pause();
    while (sb.phase != PH_IDLE) begin
      if (noisy) begin
        it = noise_tick();
      end else begin
        it = '0;
        it.sda_level = 1'b1;
        it.scl_level = 1'b1;
        it.go = (sb.phase == PH_DONE);
      end
      case (sb.phase)
        PH_WAIT_BUS: begin
          if (waited < busy_ticks) begin
            waited++;
            {it.sda_level, it.scl_level} = 2'($urandom_range(0, 2));
          end else begin
            {it.sda_level, it.scl_level} = 2'b11;
          end
        end
        PH_ACK_HIGH: begin
          // only the last tick of the high phase is sampled
          frame = sb.in_data_frame ? int'(count) - int'(sb.left) : 0;
          if (!noisy || sb.last_tick(sb.half_len)) it.sda_level = (frame == nack_at);
        end
        PH_LOAD: begin
          if (noisy) it.byte_valid = ($urandom_range(0, 2) == 0);
          else begin
            it.byte_valid = 1'b1;
            it.data_byte = sb.left[0] ? fill : ~fill;
          end
        end
        default: ;
      endcase
      push_tick(it);
      sender_pause();
    end
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
      if (stall > 0) stall--;
      else if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall = int'($urandom_range(1, 8));
      end
      out_ready <= (stall == 0);
    end
  end

  initial begin : watchdog
    int dead;
    dead = 0;
    while (dead < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) dead = 0;
      else dead++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    int base;
    int xfers;
    int r;
    int nack;
    int busy;
    logic [BYTE_W-1:0] count;
    logic [LEN_W-1:0] half;
    logic [LEN_W-1:0] hold;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset address with short timing, bus busy for a few ticks, address frame only
    write_reg(CFG_HALF_BIT, 16'd2);
    write_reg(CFG_START_HOLD, 16'd3);
    cfg_we <= 1'b0;
    run_xfer(8'd0, -1, 3, 1'b0, 8'h00);
    reconfigure(7'h7F, 16'd0, 16'd0);
    run_xfer(8'd2, -1, 0, 1'b0, 8'hFF);
    run_xfer(8'd1, 0, 0, 1'b0, 8'hA5);
    run_xfer(8'd3, 2, 1, 1'b0, 8'h00);
    // receiver holds off while requests keep coming
    hold_req = 1'b1;
    run_xfer(8'd2, -1, 0, 1'b0, 8'h81);
    run_xfer(8'd255, 3, 2, 1'b1, 8'h00);
    reconfigure(7'h2A, 16'd6, 16'd40);
    run_xfer(8'd1, -1, 0, 1'b0, 8'h3C);
    reconfigure(7'h55, 16'hFFFF, 16'd1);
    idle_ticks(16);

    base = sb.taken;
    xfers = 0;
    while (sb.taken - base < RANDOM_ITEMS) begin
      if (sb.taken - base > RANDOM_ITEMS - 300) quiet = 1'b1;
      if (!quiet && xfers % 8 == 0) begin
        half = ($urandom_range(0, 5) == 0) ? LEN_W'($urandom_range(4, 6))
                                           : LEN_W'($urandom_range(0, 3));
        hold = ($urandom_range(0, 5) == 0) ? LEN_W'($urandom_range(10, 40))
                                           : LEN_W'($urandom_range(0, 4));
        reconfigure(ADDR_W'($urandom), half, hold);
      end
      idle_ticks(int'($urandom_range(0, 4)));
      r = int'($urandom_range(0, 9));
      if (r < 7) count = BYTE_W'($urandom_range(0, 3));
      else if (r < 9) count = BYTE_W'($urandom_range(4, 8));
      else count = BYTE_W'($urandom_range(9, 16));
      r = int'($urandom_range(0, 19));
      if (r < 2) nack = 0;
      else if (r < 5) nack = int'($urandom_range(1, (count == 0) ? 1 : int'(count)));
      else nack = -1;
      busy = ($urandom_range(0, 1) == 0) ? int'($urandom_range(1, 6)) : 0;
      run_xfer(count, nack, busy, ($urandom_range(0, 4) != 0), BYTE_W'($urandom));
      xfers++;
    end

    quiet = 1'b1;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

[files.f]
hw/rtl/i2cmw_pkg.sv
hw/rtl/i2cmw_timer.sv
hw/rtl/i2cmw_ctrl.sv
hw/rtl/i2c_master_write_core.sv
tb/tb.sv
